[src/ipc_pkg.sv]
package ipc_pkg;

  localparam int unsigned ADDR_W = 128;
  localparam int unsigned LEN_W  = 8;

  localparam logic [LEN_W-1:0] V4_BITS = 8'd32;
  localparam logic [LEN_W-1:0] V6_BITS = 8'd128;

  localparam logic FAM_V4 = 1'b0;
  localparam logic FAM_V6 = 1'b1;

  // sign codes of the order field
  localparam logic [1:0] ORD_LESS    = 2'b11;
  localparam logic [1:0] ORD_EQUAL   = 2'b00;
  localparam logic [1:0] ORD_GREATER = 2'b01;

  typedef struct packed {
    logic              family;
    logic [LEN_W-1:0]  bits;
    logic [ADDR_W-1:0] addr;
  } ipc_value_t;

  typedef struct packed {
    logic [1:0] order;
    logic       is_less;
    logic       is_less_equal;
    logic       is_equal;
    logic       is_greater_equal;
    logic       is_greater;
    logic       is_not_equal;
    logic       within_res;
    logic       within_or_same;
    logic       contains;
    logic       contains_or_same;
    logic       first_host_bits_clear;
  } ipc_result_t;

  // top n bits set, n in 0..128
  function automatic logic [ADDR_W-1:0] top_mask(input logic [LEN_W-1:0] n);
    top_mask = ~({ADDR_W{1'b1}} >> n);
  endfunction

  // family maximum prefix length
  function automatic logic [LEN_W-1:0] fam_max(input logic family);
    fam_max = (family == FAM_V6) ? V6_BITS : V4_BITS;
  endfunction

endpackage

[src/ipc_compare.sv]
module ipc_compare (
  input  ipc_pkg::ipc_value_t  a,
  input  ipc_pkg::ipc_value_t  b,
  output ipc_pkg::ipc_result_t res
);

  logic [ipc_pkg::LEN_W-1:0]  a_max, b_max, a_len, b_len, min_len;
  logic [ipc_pkg::ADDR_W-1:0] m_a, m_b, m_min, m_fam, diff;
  logic [ipc_pkg::ADDR_W-1:0] pa, pb, fa, fb;
  logic                       same, match_a, match_b;
  logic [1:0]                 ord;

  always_comb begin
    a_max   = ipc_pkg::fam_max(a.family);
    b_max   = ipc_pkg::fam_max(b.family);
    a_len   = (a.bits > a_max) ? a_max : a.bits;
    b_len   = (b.bits > b_max) ? b_max : b.bits;
    min_len = (a_len < b_len) ? a_len : b_len;
    same    = (a.family == b.family);

    m_a   = ipc_pkg::top_mask(a_len);
    m_b   = ipc_pkg::top_mask(b_len);
    m_min = ipc_pkg::top_mask(min_len);
    m_fam = ipc_pkg::top_mask(a_max);

    diff    = a.addr ^ b.addr;
    match_a = ((diff & m_a) == '0);
    match_b = ((diff & m_b) == '0);

    pa = a.addr & m_min;
    pb = b.addr & m_min;
    fa = a.addr & m_fam;
    fb = b.addr & m_fam;

    if (!same) begin
      ord = (a.family > b.family) ? ipc_pkg::ORD_GREATER : ipc_pkg::ORD_LESS;
    end else if (pa != pb) begin
      ord = (pa > pb) ? ipc_pkg::ORD_GREATER : ipc_pkg::ORD_LESS;
    end else if (a_len != b_len) begin
      ord = (a_len > b_len) ? ipc_pkg::ORD_GREATER : ipc_pkg::ORD_LESS;
    end else if (fa != fb) begin
      ord = (fa > fb) ? ipc_pkg::ORD_GREATER : ipc_pkg::ORD_LESS;
    end else begin
      ord = ipc_pkg::ORD_EQUAL;
    end

    res.order            = ord;
    res.is_less          = (ord == ipc_pkg::ORD_LESS);
    res.is_less_equal    = (ord != ipc_pkg::ORD_GREATER);
    res.is_equal         = (ord == ipc_pkg::ORD_EQUAL);
    res.is_greater_equal = (ord != ipc_pkg::ORD_LESS);
    res.is_greater       = (ord == ipc_pkg::ORD_GREATER);
    res.is_not_equal     = (ord != ipc_pkg::ORD_EQUAL);

    res.within_res       = same && (a_len >  b_len) && match_b;
    res.within_or_same   = same && (a_len >= b_len) && match_b;
    res.contains         = same && (a_len <  b_len) && match_a;
    res.contains_or_same = same && (a_len <= b_len) && match_a;

    // host bits: inside the family width, beyond the prefix
    res.first_host_bits_clear = ((a.addr & m_fam & ~m_a) == '0);
  end

endmodule

[src/ip_prefix_compare_contain_core.sv]
// IPv4/IPv6 network compare and containment core.
//
// Input channel (in_valid/in_ready) carries one item: two network values,
// each a family, a prefix length and a 128-bit address split in hi/lo
// halves, IPv4 in the top 32 bits. Output channel (out_valid/out_ready)
// carries one result item per input item: order sign, six relational flags,
// four containment flags and the host-bits-clear flag of the first value.
//
// Two register stages: an input register, the compare logic, a result
// register. An accepted item is loaded into the input register, then into
// the result register, from which it is taken. Throughput is one item per
// cycle while the receiver does not stall; the critical path is the masked
// 128-bit magnitude compare between the two registers.
//
// When the receiver stalls, the result register holds, and the input
// register still takes one more item; in_ready drops only when both stages
// are full and out_ready is low. Synchronous reset empties both stages;
// the block carries no other state.
module ip_prefix_compare_contain_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              a_family,
  input  logic [7:0]        a_bits,
  input  logic [63:0]       a_addr_hi,
  input  logic [63:0]       a_addr_lo,
  input  logic              b_family,
  input  logic [7:0]        b_bits,
  input  logic [63:0]       b_addr_hi,
  input  logic [63:0]       b_addr_lo,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [1:0] order,
  output logic              is_less,
  output logic              is_less_equal,
  output logic              is_equal,
  output logic              is_greater_equal,
  output logic              is_greater,
  output logic              is_not_equal,
  output logic              within_res,
  output logic              within_or_same,
  output logic              contains,
  output logic              contains_or_same,
  output logic              first_host_bits_clear
);

  // input stage
  logic                 s1_valid;
  ipc_pkg::ipc_value_t  s1_a, s1_b;

  // result stage
  ipc_pkg::ipc_result_t res, cmp_res;
  logic                 out_adv;

  assign out_adv  = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (out_adv) out_valid <= s1_valid;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_a <= '{family: a_family, bits: a_bits, addr: {a_addr_hi, a_addr_lo}};
      s1_b <= '{family: b_family, bits: b_bits, addr: {b_addr_hi, b_addr_lo}};
    end
    if (out_adv && s1_valid) res <= cmp_res;
  end

  ipc_compare u_compare (
    .a   (s1_a),
    .b   (s1_b),
    .res (cmp_res)
  );

  assign order                 = $signed(res.order);
  assign is_less               = res.is_less;
  assign is_less_equal         = res.is_less_equal;
  assign is_equal              = res.is_equal;
  assign is_greater_equal      = res.is_greater_equal;
  assign is_greater            = res.is_greater;
  assign is_not_equal          = res.is_not_equal;
  assign within_res            = res.within_res;
  assign within_or_same        = res.within_or_same;
  assign contains              = res.contains;
  assign contains_or_same      = res.contains_or_same;
  assign first_host_bits_clear = res.first_host_bits_clear;

endmodule

[src/ipc_checker.sv]
module ipc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] order,
  input logic       is_less,
  input logic       is_equal,
  input logic       is_greater,
  input logic       within_res,
  input logic       within_or_same,
  input logic       contains
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(order) && $stable(within_res))
    else $error("result changed while stalled");

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // exactly one of less, equal, greater
  a_ord_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({is_less, is_equal, is_greater}))
    else $error("relational flags inconsistent");

  // strict subset implies non-strict and excludes superset
  a_within: assert property (@(posedge clk) disable iff (rst)
    out_valid && within_res |-> within_or_same && !contains && !is_equal)
    else $error("containment flags inconsistent");

endmodule

bind ip_prefix_compare_contain_core ipc_checker u_ipc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .order          (order),
  .is_less        (is_less),
  .is_equal       (is_equal),
  .is_greater     (is_greater),
  .within_res     (within_res),
  .within_or_same (within_or_same),
  .contains       (contains)
);
